>>> design/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad code lock
// Field widths, mode and event codes, key codes, register indexes and the
// packed layout of one result request.
// ----------------------------------------------------------------------------
package kcl_pkg;

    // default entry buffer depth
    localparam int MAX_DIGITS_DEF = 16;

    // field widths
    localparam int KEY_W      = 4;
    localparam int MODE_W     = 3;
    localparam int EVENT_W    = 4;
    localparam int COUNT_W    = 5;
    localparam int SEC_W      = 8;
    localparam int FAIL_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;

    // operating modes
    typedef enum logic [MODE_W-1:0] {
        MODE_ENTRY    = 3'd0,
        MODE_UNLOCKED = 3'd1,
        MODE_LOCKOUT  = 3'd2,
        MODE_VERIFY   = 3'd3,
        MODE_NEWPIN   = 3'd4
    } mode_t;

    // result events
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE        = 4'd0,
        EV_DIGIT       = 4'd1,
        EV_MATCH       = 4'd2,
        EV_MISMATCH    = 4'd3,
        EV_LOCKOUT     = 4'd4,
        EV_CLEARED     = 4'd5,
        EV_CHANGED     = 4'd6,
        EV_EMPTY       = 4'd7,
        EV_VERIFY_FAIL = 4'd8
    } event_t;

    // request kinds carried in tuser
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // key codes
    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [KEY_W-1:0] KEY_CHANGE    = 4'd10;
    localparam logic [KEY_W-1:0] KEY_BACK      = 4'd11;
    localparam logic [KEY_W-1:0] KEY_CLEAR     = 4'd14;
    localparam logic [KEY_W-1:0] KEY_SUBMIT    = 4'd15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_SEC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAIL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_SEC = 2'd2;

    // configuration reset values
    localparam logic [SEC_W-1:0]  UNLOCK_SEC_RST  = 8'd5;
    localparam logic [FAIL_W-1:0] MAX_FAIL_RST    = 4'd5;
    localparam logic [SEC_W-1:0]  LOCKOUT_SEC_RST = 8'd30;

    // one result, unlock in the lowest bit
    typedef struct packed {
        logic [FAIL_W-1:0]  failures;
        logic [SEC_W-1:0]   seconds_left;
        logic [COUNT_W-1:0] entry_count;
        event_t             event_res;
        mode_t              mode;
        logic               unlock;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

>>> design/keypad_code_lock_top.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_top: keypad combination lock
// Collects digit keys, checks submitted entries against the stored PIN,
// drives the unlock output, counts failures and handles PIN change.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one request per key press or one-second tick; s_axis_tuser
//   selects the kind (0 key, 1 tick), s_axis_tdata[3:0] holds the key code.
//   m_axis: exactly one result request per input request, in order.
//   cfg: plain write port for unlock_seconds, max_failures, lockout_seconds;
//   write it only while no request is in flight.
// Timing
//   A request passes an input register and then one pass of logic that
//   updates the lock state and loads the output register, from which its
//   result shows on m_axis. One request per cycle is taken sustained
//   while m_axis does not stall.
// Reset and stall
//   aresetn clears the mode, counters, stored PIN length and both stages;
//   the stored PIN becomes empty. A stalled m_axis holds its result while
//   the input register still takes one more request before s_axis_tready
//   drops.
// ----------------------------------------------------------------------------
module keypad_code_lock_top #(
    parameter int MAX_DIGITS = kcl_pkg::MAX_DIGITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // tdata: key_code[3:0], zero pad
    input  logic [kcl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: opcode[0]
    input  logic [kcl_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: unlock[0], mode[3:1], event_res[7:4], entry_count[12:8],
    //        seconds_left[20:13], failures[24:21], zero pad
    output logic [kcl_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_wr_en,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kcl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import kcl_pkg::*;

    localparam int LEN_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_DIGITS);

    // configuration
    logic [SEC_W-1:0]  unlock_sec_reg;
    logic [FAIL_W-1:0] max_fail_reg;
    logic [SEC_W-1:0]  lockout_sec_reg;

    // input stage
    logic             in_valid_reg;
    logic             in_op_reg;
    logic [KEY_W-1:0] in_key_reg;

    // lock state
    mode_t             mode_reg, mode_next;
    logic [LEN_W-1:0]  entry_len_reg, entry_len_next;
    logic [LEN_W-1:0]  stored_len_reg, stored_len_next;
    logic [FAIL_W-1:0] fail_reg, fail_next;
    logic [SEC_W-1:0]  countdown_reg, countdown_next;
    logic              unlock_reg, unlock_next;
    logic [KEY_W-1:0]  entry_digits_reg [MAX_DIGITS];
    logic [KEY_W-1:0]  stored_pin_reg [MAX_DIGITS];

    // output stage
    logic    out_valid_reg;
    result_t result_reg, result_next;

    logic              fire;
    logic              pin_match;
    logic              digit_wr;
    logic              pin_copy;
    event_t            event_next;
    logic [FAIL_W:0]   fail_inc;

    // one request processed when the output register is free or drains
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, result_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unlock_sec_reg  <= UNLOCK_SEC_RST;
            max_fail_reg    <= MAX_FAIL_RST;
            lockout_sec_reg <= LOCKOUT_SEC_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_UNLOCK_SEC:  unlock_sec_reg  <= cfg_wdata;
                CFG_MAX_FAIL:    max_fail_reg    <= cfg_wdata[FAIL_W-1:0];
                CFG_LOCKOUT_SEC: lockout_sec_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // entry equals stored pin: same length and all live digits equal
    always_comb begin
        pin_match = (entry_len_reg == stored_len_reg);
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if ((LEN_W'(k) < entry_len_reg) && (entry_digits_reg[k] != stored_pin_reg[k])) begin
                pin_match = 1'b0;
            end
        end
    end

    assign fail_inc = {1'b0, fail_reg} + 1'b1;

    // next state
    always_comb begin
        mode_next       = mode_reg;
        entry_len_next  = entry_len_reg;
        stored_len_next = stored_len_reg;
        fail_next       = fail_reg;
        countdown_next  = countdown_reg;
        unlock_next     = unlock_reg;
        event_next      = EV_NONE;
        digit_wr        = 1'b0;
        pin_copy        = 1'b0;
        if (in_op_reg == OP_TICK) begin
            // timed modes count down and fall back to entry
            if (mode_reg == MODE_UNLOCKED || mode_reg == MODE_LOCKOUT) begin
                if (countdown_reg <= SEC_W'(1)) begin
                    countdown_next = '0;
                    unlock_next    = 1'b0;
                    mode_next      = MODE_ENTRY;
                end else begin
                    countdown_next = countdown_reg - 1'b1;
                end
            end
        end else if (mode_reg == MODE_ENTRY || mode_reg == MODE_VERIFY ||
                     mode_reg == MODE_NEWPIN) begin
            if (in_key_reg <= KEY_DIGIT_MAX) begin
                // digit, dropped once the buffer is full
                if (entry_len_reg < LEN_FULL) begin
                    digit_wr       = 1'b1;
                    entry_len_next = entry_len_reg + 1'b1;
                    event_next     = EV_DIGIT;
                end
            end else begin
                unique case (in_key_reg)
                    KEY_CLEAR: begin
                        entry_len_next = '0;
                        event_next     = EV_CLEARED;
                    end
                    KEY_BACK: begin
                        if (entry_len_reg != '0) begin
                            entry_len_next = entry_len_reg - 1'b1;
                        end
                    end
                    KEY_CHANGE: begin
                        if (mode_reg == MODE_ENTRY) begin
                            entry_len_next = '0;
                            mode_next      = MODE_VERIFY;
                        end
                    end
                    KEY_SUBMIT: begin
                        if (mode_reg == MODE_NEWPIN) begin
                            // store the new pin as entered
                            pin_copy        = 1'b1;
                            stored_len_next = entry_len_reg;
                            entry_len_next  = '0;
                            mode_next       = MODE_ENTRY;
                            event_next      = EV_CHANGED;
                        end else if (mode_reg == MODE_VERIFY) begin
                            entry_len_next = '0;
                            mode_next      = pin_match ? MODE_NEWPIN : MODE_ENTRY;
                            event_next     = pin_match ? EV_MATCH : EV_VERIFY_FAIL;
                        end else if (entry_len_reg == '0) begin
                            event_next = EV_EMPTY;
                        end else if (pin_match) begin
                            entry_len_next = '0;
                            fail_next      = '0;
                            mode_next      = MODE_UNLOCKED;
                            unlock_next    = 1'b1;
                            countdown_next = unlock_sec_reg;
                            event_next     = EV_MATCH;
                        end else begin
                            // failure, lockout at the limit (zero limit acts as one)
                            entry_len_next = '0;
                            if (fail_inc >= {1'b0, max_fail_reg}) begin
                                fail_next      = '0;
                                mode_next      = MODE_LOCKOUT;
                                countdown_next = lockout_sec_reg;
                                event_next     = EV_LOCKOUT;
                            end else begin
                                fail_next  = fail_inc[FAIL_W-1:0];
                                event_next = EV_MISMATCH;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result fields from the updated state
    always_comb begin
        result_next.unlock      = unlock_next;
        result_next.mode        = mode_next;
        result_next.event_res   = event_next;
        result_next.entry_count = COUNT_W'(entry_len_next);
        result_next.failures    = fail_next;
        if (mode_next == MODE_UNLOCKED || mode_next == MODE_LOCKOUT) begin
            result_next.seconds_left = countdown_next;
        end else begin
            result_next.seconds_left = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= MODE_ENTRY;
            entry_len_reg  <= '0;
            stored_len_reg <= '0;
            fail_reg       <= '0;
            countdown_reg  <= '0;
            unlock_reg     <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (fire) begin
                out_valid_reg  <= 1'b1;
                mode_reg       <= mode_next;
                entry_len_reg  <= entry_len_next;
                stored_len_reg <= stored_len_next;
                fail_reg       <= fail_next;
                countdown_reg  <= countdown_next;
                unlock_reg     <= unlock_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_op_reg  <= s_axis_tuser[0];
            in_key_reg <= s_axis_tdata[KEY_W-1:0];
        end
        if (fire) begin
            result_reg <= result_next;
        end
        if (fire && digit_wr) begin
            entry_digits_reg[entry_len_reg[IDX_W-1:0]] <= in_key_reg;
        end
        if (fire && pin_copy) begin
            stored_pin_reg <= entry_digits_reg;
        end
    end

endmodule

>>> design/kcl_checker.sv
// ----------------------------------------------------------------------------
// kcl_checker: port-level checks of the keypad code lock
// Watches the result stream and checks relations between result fields.
// ----------------------------------------------------------------------------
module kcl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic [kcl_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready
);
    import kcl_pkg::*;

    result_t res;
    logic    timed;

    assign res   = result_t'(m_axis_tdata[RESULT_W-1:0]);
    assign timed = (res.mode == MODE_UNLOCKED) || (res.mode == MODE_LOCKOUT);

    // a stalled result stays put
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // door drive only in unlocked mode
    a_unlock_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (res.unlock == (res.mode == MODE_UNLOCKED)))
        else $error("unlock output disagrees with mode");

    // countdown shown only in timed modes
    a_seconds_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !timed |-> (res.seconds_left == '0))
        else $error("seconds left outside unlock or lockout");

    // timed modes start with an empty entry and no failures
    a_timed_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && timed |-> (res.entry_count == '0) && (res.failures == '0))
        else $error("entry or failures left over in timed mode");

endmodule

bind keypad_code_lock_top kcl_checker u_kcl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
